/* rtl/biquad_hp_bp_filter_unit_assert.svh */
// Assertion macros used by the biquad filter controller.
`ifndef BIQUAD_HP_BP_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_HP_BP_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, disabled in reset.
`define BQF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, disabled in reset.
`define BQF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bqf_pkg.sv */
// Package with the shared types, codes and constants of the biquad filter.
package bqf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_DEF    = 22;

  // Accumulator wraps modulo 2^64.
  localparam int ACC_W     = 64;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;
  localparam int MAC_TERMS = 5;
  localparam int WARM_LEN  = 2;

  typedef enum logic [2:0] {
    REG_BAND_MODE = 3'd0,
    REG_LP_B0     = 3'd1,
    REG_LP_A1     = 3'd2,
    REG_LP_A2     = 3'd3,
    REG_HP_B0     = 3'd4,
    REG_HP_A1     = 3'd5,
    REG_HP_A2     = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    TERM_X0 = 3'd0,
    TERM_X1 = 3'd1,
    TERM_X2 = 3'd2,
    TERM_Y1 = 3'd3,
    TERM_Y2 = 3'd4
  } term_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LP_MAC,
    ST_LP_WB,
    ST_HP_MAC,
    ST_HP_WB,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  load;
    logic  stage_hp;
    logic  mul_en;
    term_e mul_term;
    logic  acc_init;
    logic  acc_en;
    term_e acc_term;
    logic  wb;
    logic  out_load;
  } cmd_t;

endpackage

/* rtl/bqf_regs.sv */
// Configuration register file with its APB-style access port.
module bqf_regs import bqf_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         band_mode_o,
  output logic signed [COEF_WIDTH-1:0] lp_b0_o,
  output logic signed [COEF_WIDTH-1:0] lp_a1_o,
  output logic signed [COEF_WIDTH-1:0] lp_a2_o,
  output logic signed [COEF_WIDTH-1:0] hp_b0_o,
  output logic signed [COEF_WIDTH-1:0] hp_a1_o,
  output logic signed [COEF_WIDTH-1:0] hp_a2_o
);

  logic                  band_mode_q;
  logic [COEF_WIDTH-1:0] lp_b0_q, lp_a1_q, lp_a2_q, hp_b0_q, hp_a1_q, hp_a2_q;
  logic                  wr_en;
  reg_idx_e              idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_mode_q <= 1'b0;
      lp_b0_q     <= '0;
      lp_a1_q     <= '0;
      lp_a2_q     <= '0;
      hp_b0_q     <= '0;
      hp_a1_q     <= '0;
      hp_a2_q     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BAND_MODE: band_mode_q <= pwdata[0];
        REG_LP_B0:     lp_b0_q     <= pwdata[COEF_WIDTH-1:0];
        REG_LP_A1:     lp_a1_q     <= pwdata[COEF_WIDTH-1:0];
        REG_LP_A2:     lp_a2_q     <= pwdata[COEF_WIDTH-1:0];
        REG_HP_B0:     hp_b0_q     <= pwdata[COEF_WIDTH-1:0];
        REG_HP_A1:     hp_a1_q     <= pwdata[COEF_WIDTH-1:0];
        REG_HP_A2:     hp_a2_q     <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BAND_MODE: prdata = APB_DW'(band_mode_q);
      REG_LP_B0:     prdata = APB_DW'(lp_b0_q);
      REG_LP_A1:     prdata = APB_DW'(lp_a1_q);
      REG_LP_A2:     prdata = APB_DW'(lp_a2_q);
      REG_HP_B0:     prdata = APB_DW'(hp_b0_q);
      REG_HP_A1:     prdata = APB_DW'(hp_a1_q);
      REG_HP_A2:     prdata = APB_DW'(hp_a2_q);
      default:       prdata = '0;
    endcase
  end

  assign band_mode_o = band_mode_q;
  assign lp_b0_o     = lp_b0_q;
  assign lp_a1_o     = lp_a1_q;
  assign lp_a2_o     = lp_a2_q;
  assign hp_b0_o     = hp_b0_q;
  assign hp_a1_o     = hp_a1_q;
  assign hp_a2_o     = hp_a2_q;

endmodule

/* rtl/bqf_datapath.sv */
// Datapath: histories, shared multiplier, accumulator, rounding and output register.
module bqf_datapath import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int COEF_FRAC    = COEF_FRAC_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           buffer_start_i,
  input  logic                           band_mode_i,
  input  logic signed [COEF_WIDTH-1:0]   lp_b0_i,
  input  logic signed [COEF_WIDTH-1:0]   lp_a1_i,
  input  logic signed [COEF_WIDTH-1:0]   lp_a2_i,
  input  logic signed [COEF_WIDTH-1:0]   hp_b0_i,
  input  logic signed [COEF_WIDTH-1:0]   hp_a1_i,
  input  logic signed [COEF_WIDTH-1:0]   hp_a2_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] lp_ih_q [2];
  logic signed [SAMPLE_WIDTH-1:0] lp_oh_q [2];
  logic signed [SAMPLE_WIDTH-1:0] hp_ih_q [2];
  logic signed [SAMPLE_WIDTH-1:0] hp_oh_q [2];
  logic [1:0]                     warm_cnt_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic signed [SAMPLE_WIDTH-1:0] xs, samp_sel, y;
  logic signed [COEF_WIDTH-1:0]   coef_sel;
  logic signed [ACC_W-1:0]        p_ext, acc_d, r;
  logic                           warm;

  assign warm = (warm_cnt_q < 2'(WARM_LEN));
  assign xs   = cmd_i.stage_hp ? (band_mode_i ? lp_oh_q[0] : x_q) : x_q;

  always_comb begin
    case (cmd_i.mul_term)
      TERM_X0: samp_sel = xs;
      TERM_X1: samp_sel = cmd_i.stage_hp ? hp_ih_q[0] : lp_ih_q[0];
      TERM_X2: samp_sel = cmd_i.stage_hp ? hp_ih_q[1] : lp_ih_q[1];
      TERM_Y1: samp_sel = cmd_i.stage_hp ? hp_oh_q[0] : lp_oh_q[0];
      TERM_Y2: samp_sel = cmd_i.stage_hp ? hp_oh_q[1] : lp_oh_q[1];
      default: samp_sel = '0;
    endcase
    case (cmd_i.mul_term)
      TERM_X0, TERM_X1, TERM_X2: coef_sel = cmd_i.stage_hp ? hp_b0_i : lp_b0_i;
      TERM_Y1: coef_sel = cmd_i.stage_hp ? hp_a1_i : lp_a1_i;
      TERM_Y2: coef_sel = cmd_i.stage_hp ? hp_a2_i : lp_a2_i;
      default: coef_sel = '0;
    endcase
  end

  // The middle feed-forward tap is twice b0, added for low-pass, subtracted for high-pass.
  always_comb begin
    p_ext = ACC_W'(prod_q);
    case (cmd_i.acc_term)
      TERM_X0, TERM_X2: acc_d = acc_q + p_ext;
      TERM_X1: acc_d = cmd_i.stage_hp ? acc_q - (p_ext <<< 1) : acc_q + (p_ext <<< 1);
      TERM_Y1, TERM_Y2: acc_d = acc_q - p_ext;
      default: acc_d = acc_q;
    endcase
  end

  always_comb begin
    r = acc_q >>> COEF_FRAC;
    if (warm) begin
      y = '0;
    end else if (r > SAT_HI) begin
      y = SAMPLE_WIDTH'(SAT_HI);
    end else if (r < SAT_LO) begin
      y = SAMPLE_WIDTH'(SAT_LO);
    end else begin
      y = SAMPLE_WIDTH'(r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= coef_sel * samp_sel;
    end
    if (cmd_i.acc_init) begin
      acc_q <= ROUND;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.out_load) begin
      out_q <= hp_oh_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_ih_q    <= '{default: '0};
      lp_oh_q    <= '{default: '0};
      hp_ih_q    <= '{default: '0};
      hp_oh_q    <= '{default: '0};
      warm_cnt_q <= '0;
    end else if (cmd_i.load && buffer_start_i) begin
      lp_ih_q    <= '{default: '0};
      lp_oh_q    <= '{default: '0};
      hp_ih_q    <= '{default: '0};
      hp_oh_q    <= '{default: '0};
      warm_cnt_q <= '0;
    end else if (cmd_i.wb) begin
      if (cmd_i.stage_hp) begin
        hp_ih_q[1] <= hp_ih_q[0];
        hp_ih_q[0] <= xs;
        hp_oh_q[1] <= hp_oh_q[0];
        hp_oh_q[0] <= y;
        if (warm) begin
          warm_cnt_q <= warm_cnt_q + 2'd1;
        end
      end else begin
        lp_ih_q[1] <= lp_ih_q[0];
        lp_ih_q[0] <= xs;
        lp_oh_q[1] <= lp_oh_q[0];
        lp_oh_q[0] <= y;
      end
    end
  end

  assign sample_out_o = out_q;

endmodule

/* rtl/bqf_ctrl.sv */
// Controller state machine sequencing the two biquad stages and the output handshake.
module bqf_ctrl import bqf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  `include "biquad_hp_bp_filter_unit_assert.svh"

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       mac_st;

  assign mac_st = (state_q == ST_LP_MAC) || (state_q == ST_HP_MAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.stage_hp = (state_q == ST_HP_MAC) || (state_q == ST_HP_WB);
    cmd_o.mul_term = term_e'(cnt_q);
    cmd_o.acc_term = term_e'(cnt_q - 3'd1);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_LP_MAC;
        end
      end
      ST_LP_MAC, ST_HP_MAC: begin
        cmd_o.mul_en   = (cnt_q < 3'(MAC_TERMS));
        cmd_o.acc_init = (cnt_q == 3'd0);
        cmd_o.acc_en   = (cnt_q != 3'd0);
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == 3'(MAC_TERMS)) begin
          state_d = (state_q == ST_LP_MAC) ? ST_LP_WB : ST_HP_WB;
        end
      end
      ST_LP_WB: begin
        cmd_o.wb = 1'b1;
        cnt_d    = '0;
        state_d  = ST_HP_MAC;
      end
      ST_HP_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `BQF_ASSERT_NEXT(a_accept_starts_lp, state_q == ST_IDLE && in_valid_i, state_q == ST_LP_MAC, "accepted transaction did not start the low-pass stage")
  `BQF_ASSERT_IMPL(a_cnt_bound, mac_st, cnt_q <= 3'(MAC_TERMS), "MAC step counter out of range")
  `BQF_ASSERT_IMPL(a_valid_from_out, $rose(out_valid_q), $past(state_q) == ST_OUT, "result raised outside the output state")

endmodule

/* rtl/biquad_hp_bp_filter_unit.sv */
// Top level of the biquad high-pass / band-pass filter unit.
// An accepted transaction runs the low-pass stage, then the high-pass stage; each stage
// makes five products on the shared multiplier, a last accumulate and a write-back. The result
// is then loaded into the output register; no new transaction is taken before that load.
// Reset: asynchronous, active low; clears coefficients, mode, all histories and warm-up.
// The first two results after reset or a buffer start are zero.
module biquad_hp_bp_filter_unit import bqf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int COEF_FRAC    = COEF_FRAC_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel: one sample transaction is taken when valid is high and stall is low.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           buffer_start_i,
  // Output channel: one filtered sample per input transaction.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  // Configuration port, register i at byte address 4*i.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_AW-1:0]              paddr,
  input  logic [APB_DW-1:0]              pwdata,
  output logic [APB_DW-1:0]              prdata,
  output logic                           pready
);

  // Command bundle from the controller to the datapath.
  cmd_t cmd;

  logic                         band_mode;
  logic signed [COEF_WIDTH-1:0] lp_b0, lp_a1, lp_a2, hp_b0, hp_a1, hp_a2;

  // The configuration port never inserts wait states.
  assign pready = 1'b1;

  bqf_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .band_mode_o (band_mode),
    .lp_b0_o     (lp_b0),
    .lp_a1_o     (lp_a1),
    .lp_a2_o     (lp_a2),
    .hp_b0_o     (hp_b0),
    .hp_a1_o     (hp_a1),
    .hp_a2_o     (hp_a2)
  );

  // The controller accepts a transaction only when idle, while a finished result
  // may still be waiting in the output register for the downstream side.
  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath runs the low-pass stage first so that its output can feed the
  // high-pass stage in band-pass mode; in high-pass mode the low-pass history
  // still advances but its output is not used.
  bqf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .COEF_FRAC    (COEF_FRAC)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_in_i    (sample_in_i),
    .buffer_start_i (buffer_start_i),
    .band_mode_i    (band_mode),
    .lp_b0_i        (lp_b0),
    .lp_a1_i        (lp_a1),
    .lp_a2_i        (lp_a2),
    .hp_b0_i        (hp_b0),
    .hp_a1_i        (hp_a1),
    .hp_a2_i        (hp_a2),
    .sample_out_o   (sample_out_o)
  );

endmodule
